// File: sv/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Types, codes and sizes shared by the sequenced command fifo files.
// ----------------------------------------------------------------------------
package scf_pkg;

    // queue depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int CMD_W    = 3;
    localparam int TYPE_W   = 16;
    localparam int SIZE_W   = 16;
    localparam int HANDLE_W = 32;
    localparam int CODE_W   = 8;
    localparam int STAT_W   = 3;
    localparam int SEQ_W    = 64;
    localparam int OCC_W    = 5;
    localparam int HDR_W    = 8;
    localparam int MAXB_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SUBMIT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUBMIT_FINAL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP          = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FAIL         = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FAILED    = 3'd2;
    localparam logic [STAT_W-1:0] ST_CLOSED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    // failure code used when fail carries zero
    localparam logic [CODE_W-1:0] GENERIC_FAILURE = 8'd2;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_BYTES = 2'd1;
    localparam logic [HDR_W-1:0]     HEADER_BYTES_RST     = 8'd16;
    localparam logic [MAXB_W-1:0]    MAX_RECORD_BYTES_RST = 16'd4096;

    // command request payload
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [TYPE_W-1:0]   entry_type;
        logic [SIZE_W-1:0]   entry_size;
        logic [HANDLE_W-1:0] entry_handle;
        logic [CODE_W-1:0]   fail_code;
    } t_cmd_req;

    // result payload
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [SEQ_W-1:0]    seq_number;
        logic [HANDLE_W-1:0] out_handle;
        logic [OCC_W-1:0]    occupancy;
        logic [CODE_W-1:0]   latched_failure;
    } t_result;

    // configuration write payload
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

endpackage

// File: sv/scf_if.sv
// ----------------------------------------------------------------------------
// scf_if
// Valid/ready channels of the sequenced command fifo: commands, results and
// configuration writes.
// ----------------------------------------------------------------------------

// command channel
interface scf_cmd_if;
    logic              valid;
    logic              ready;
    scf_pkg::t_cmd_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// result channel
interface scf_res_if;
    logic             valid;
    logic             ready;
    scf_pkg::t_result res;

    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

// configuration write channel
interface scf_cfg_if;
    logic              valid;
    logic              ready;
    scf_pkg::t_cfg_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// File: sv/sequenced_command_fifo.sv
// ----------------------------------------------------------------------------
// sequenced_command_fifo
// Bounded ring queue of command handles tagged with 64-bit sequence numbers,
// with close and fail.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one request per handshake: submit, submit final, pop, close
//   or fail. Every request produces exactly one result on o_res, in order.
//   i_cfg writes header_bytes (index 0) and max_record_bytes (index 1); it is
//   always ready and should be used only while no request is in flight.
// Pipeline and throughput:
//   a request is registered in the input register at acceptance, evaluated
//   against the queue state, and its result is registered in the output
//   register when o_res can take it, raising o_res.valid. One request per cycle
//   is sustained while o_res is not held; the limit is the single evaluation
//   stage that updates the ring pointers, count and sequence counter.
// Reset:
//   synchronous, active low. The queue is empty and accepting, sequence
//   numbers restart at 1, no failure is latched and both size bounds return
//   to 16 and 4096. Slot contents are not cleared.
// Stall:
//   while o_res is held the result register keeps its value; one more request
//   can wait in the input register, after which i_cmd.ready drops.
// ----------------------------------------------------------------------------
module sequenced_command_fifo (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scf_cmd_if.sink   i_cmd,
    scf_res_if.source o_res,
    scf_cfg_if.sink   i_cfg
);
    import scf_pkg::*;

    // pipeline registers
    logic     r_in_vld;
    t_cmd_req r_in;
    logic     r_out_vld;
    t_result  r_out;

    // configuration
    logic [HDR_W-1:0]  r_hdr_bytes;
    logic [MAXB_W-1:0] r_max_bytes;

    // ring storage and queue state
    logic [HANDLE_W-1:0] r_slot_handle [CAPACITY];
    logic [SEQ_W-1:0]    r_slot_seq    [CAPACITY];
    logic [IDX_W-1:0]    r_rd_idx;
    logic [IDX_W-1:0]    r_wr_idx;
    logic [CNT_W-1:0]    r_count;
    logic [SEQ_W-1:0]    r_next_seq;
    logic                r_accepting;
    logic                r_failed;
    logic [CODE_W-1:0]   r_stored_fail;

    // next values
    logic [IDX_W-1:0]    n_rd_idx;
    logic [IDX_W-1:0]    n_wr_idx;
    logic [CNT_W-1:0]    n_count;
    logic [SEQ_W-1:0]    n_next_seq;
    logic                n_accepting;
    logic                n_failed;
    logic [CODE_W-1:0]   n_stored_fail;
    logic                n_push;
    t_result             n_result;

    logic out_take;
    logic advance;
    logic bad_record;

    // handshake control
    assign out_take    = !r_out_vld || o_res.ready;
    assign advance     = r_in_vld && out_take;
    assign i_cmd.ready = !r_in_vld || out_take;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_vld;
    assign o_res.res   = r_out;

    // record check: nonzero entry type and size within the configured bounds
    assign bad_record = (r_in.entry_type == '0)
                     || (r_in.entry_size < SIZE_W'(r_hdr_bytes))
                     || (r_in.entry_size > r_max_bytes);

    // command evaluation
    always_comb begin
        n_rd_idx      = r_rd_idx;
        n_wr_idx      = r_wr_idx;
        n_count       = r_count;
        n_next_seq    = r_next_seq;
        n_accepting   = r_accepting;
        n_failed      = r_failed;
        n_stored_fail = r_stored_fail;
        n_push        = 1'b0;

        n_result.status     = ST_INVALID;
        n_result.seq_number = '0;
        n_result.out_handle = '0;

        unique case (r_in.command) inside
            CMD_SUBMIT, CMD_SUBMIT_FINAL: begin
                if (bad_record) begin
                    n_result.status = ST_INVALID;
                end else if (r_failed) begin
                    n_result.status = ST_FAILED;
                end else if (!r_accepting) begin
                    n_result.status = ST_CLOSED;
                end else if (r_count >= CNT_W'(CAPACITY)) begin
                    n_result.status = ST_FULL;
                end else if (r_next_seq == '0) begin
                    n_result.status = ST_EXHAUSTED;
                end else begin
                    n_result.status     = ST_OK;
                    n_result.seq_number = r_next_seq;
                    n_next_seq          = r_next_seq + SEQ_W'(1);
                    n_push              = 1'b1;
                    n_wr_idx            = (r_wr_idx == IDX_W'(CAPACITY - 1)) ? '0
                                        : r_wr_idx + IDX_W'(1);
                    n_count             = r_count + CNT_W'(1);
                    if (r_in.command == CMD_SUBMIT_FINAL) begin
                        n_accepting = 1'b0;
                    end
                end
            end
            CMD_POP: begin
                if (r_failed) begin
                    n_result.status = ST_FAILED;
                end else if (r_count == '0) begin
                    n_result.status = r_accepting ? ST_EXHAUSTED : ST_CLOSED;
                end else begin
                    n_result.status     = ST_OK;
                    n_result.out_handle = r_slot_handle[r_rd_idx];
                    n_result.seq_number = r_slot_seq[r_rd_idx];
                    n_rd_idx            = (r_rd_idx == IDX_W'(CAPACITY - 1)) ? '0
                                        : r_rd_idx + IDX_W'(1);
                    n_count             = r_count - CNT_W'(1);
                end
            end
            CMD_CLOSE: begin
                n_accepting     = 1'b0;
                n_result.status = ST_OK;
            end
            CMD_FAIL: begin
                n_accepting     = 1'b0;
                n_failed        = 1'b1;
                n_stored_fail   = (r_in.fail_code == '0) ? GENERIC_FAILURE
                                : r_in.fail_code;
                n_result.status = ST_OK;
            end
            default: begin
                n_result.status = ST_INVALID;
            end
        endcase

        n_result.occupancy       = OCC_W'(n_count);
        n_result.latched_failure = n_stored_fail;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_hdr_bytes   <= HEADER_BYTES_RST;
            r_max_bytes   <= MAX_RECORD_BYTES_RST;
            r_rd_idx      <= '0;
            r_wr_idx      <= '0;
            r_count       <= '0;
            r_next_seq    <= SEQ_W'(1);
            r_accepting   <= 1'b1;
            r_failed      <= 1'b0;
            r_stored_fail <= '0;
        end else begin
            if (i_cmd.ready) begin
                r_in_vld <= i_cmd.valid;
            end
            if (out_take) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_rd_idx      <= n_rd_idx;
                r_wr_idx      <= n_wr_idx;
                r_count       <= n_count;
                r_next_seq    <= n_next_seq;
                r_accepting   <= n_accepting;
                r_failed      <= n_failed;
                r_stored_fail <= n_stored_fail;
            end
            if (i_cfg.valid) begin
                case (i_cfg.req.index)
                    CFG_HEADER_BYTES:     r_hdr_bytes <= HDR_W'(i_cfg.req.data);
                    CFG_MAX_RECORD_BYTES: r_max_bytes <= i_cfg.req.data;
                    default:              ;
                endcase
            end
        end
    end

    // payload registers and slot storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.req;
        end
        if (advance) begin
            r_out <= n_result;
        end
        if (advance && n_push) begin
            r_slot_handle[r_wr_idx] <= r_in.entry_handle;
            r_slot_seq[r_wr_idx]    <= r_next_seq;
        end
    end

endmodule

// File: sv/scf_checker.sv
// ----------------------------------------------------------------------------
// scf_checker
// Port-level checks of the sequenced command fifo, bound to the top level.
// ----------------------------------------------------------------------------
module scf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input scf_pkg::t_result i_res
);
    import scf_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("result changed while stalled");

    // occupancy stays within capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res.occupancy <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    // a refused request carries no handle and no sequence
    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.status != ST_OK
        |-> i_res.out_handle == '0 && i_res.seq_number == '0)
        else $error("refused request carries payload");

    // a returned handle always comes with a real sequence number
    a_pop_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.out_handle != '0 |-> i_res.seq_number != '0)
        else $error("popped entry without sequence number");

endmodule

bind sequenced_command_fifo scf_checker u_scf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.res)
);
